>>> design/kct_pkg.sv
// shared types and constants for the keyed counter table
`default_nettype none
package kct_pkg;

    localparam int KEY_W = 31;
    localparam int CNT_W = 31;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;

    // command codes
    localparam cmd_t CMD_ADD = 2'd0;
    localparam cmd_t CMD_GET = 2'd1;
    localparam cmd_t CMD_SET = 2'd2;
    localparam cmd_t CMD_BAD = 2'd3;

    // status codes
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_BAD  = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // command word travelling down the chain of cells
    typedef struct packed {
        logic              vld;
        logic              done;
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  data;
        status_t           status;
    } kct_tok_t;

endpackage
`default_nettype wire

>>> design/kct_in_if.sv
// request channel: command, key and set value with valid/ready
`default_nettype none
interface kct_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] key;
    logic signed [31:0] set_value;

    modport source (output valid, output command, output key, output set_value, input ready);
    modport sink (input valid, input command, input key, input set_value, output ready);
endinterface
`default_nettype wire

>>> design/kct_out_if.sv
// response channel: count and status with valid/ready
`default_nettype none
interface kct_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] count_out;
    logic [1:0]  status;

    modport source (output valid, output count_out, output status, input ready);
    modport sink (input valid, input count_out, input status, output ready);
endinterface
`default_nettype wire

>>> design/kct_cell.sv
// one table entry: key, count and valid mark, plus its stage of the command chain
`default_nettype none
module kct_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire kct_pkg::kct_tok_t tok_in,
    output kct_pkg::kct_tok_t     tok_out
);
    import kct_pkg::*;

    logic             ent_vld_reg, ent_vld_next;
    logic [KEY_W-1:0] ent_key_reg, ent_key_next;
    logic [CNT_W-1:0] ent_cnt_reg, ent_cnt_next;
    kct_tok_t         tok_reg, tok_next;

    // entries fill from the low end, so the first free cell means the key is absent
    always_comb
    begin
        tok_next     = tok_in;
        ent_vld_next = ent_vld_reg;
        ent_key_next = ent_key_reg;
        ent_cnt_next = ent_cnt_reg;
        if (tok_in.vld && !tok_in.done)
        begin
            if (ent_vld_reg && (ent_key_reg == tok_in.key))
            begin
                tok_next.done   = 1'b1;
                tok_next.status = ST_OK;
                case (tok_in.cmd)
                    CMD_ADD:
                    begin
                        ent_cnt_next  = (ent_cnt_reg == CNT_MAX) ? ent_cnt_reg
                                                                 : ent_cnt_reg + 1'b1;
                        tok_next.data = ent_cnt_next;
                    end
                    CMD_GET: tok_next.data = ent_cnt_reg;
                    CMD_SET: ent_cnt_next = tok_in.data;
                    default: ;
                endcase
            end
            else if (!ent_vld_reg)
            begin
                tok_next.done   = 1'b1;
                tok_next.status = ST_OK;
                case (tok_in.cmd)
                    CMD_ADD:
                    begin
                        ent_vld_next  = 1'b1;
                        ent_key_next  = tok_in.key;
                        ent_cnt_next  = CNT_W'(1);
                        tok_next.data = CNT_W'(1);
                    end
                    CMD_GET: tok_next.data = '0;
                    CMD_SET:
                    begin
                        ent_vld_next = 1'b1;
                        ent_key_next = tok_in.key;
                        ent_cnt_next = tok_in.data;
                    end
                    default: ;
                endcase
            end
        end
    end

    // valid mark and chain stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= 1'b0;
            tok_reg     <= '0;
        end
        else if (adv)
        begin
            ent_vld_reg <= ent_vld_next;
            tok_reg     <= tok_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent_key_reg <= ent_key_next;
            ent_cnt_reg <= ent_cnt_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

>>> design/keyed_counter_table_top.sv
// keyed counter table: chain of entry cells that each command word walks through
// a request word passes the input register, every entry cell and the output register before its response is valid
// throughput: one word per cycle unless a response waits; every cell then takes one step of the chain per cycle
// the whole chain holds while a response waits unaccepted
// reset clears all valid marks at once; the table is usable in the first cycle after reset
`default_nettype none
module keyed_counter_table_top #(
    parameter int ENTRIES = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    kct_in_if.sink    req,
    kct_out_if.source rsp
);
    import kct_pkg::*;

    logic              adv;
    logic              bad;
    kct_tok_t          tok0_reg, tok0_next;
    kct_tok_t          chain [ENTRIES+1];
    kct_tok_t          last;
    logic              out_vld_reg;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    status_t           out_st_reg, out_st_next;

    // chain moves whenever the output register is free or being drained
    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    // screen the request and form the entry word
    always_comb
    begin
        bad = (req.command == CMD_BAD) || req.key[31] ||
              ((req.command == CMD_SET) && req.set_value[31]);
        tok0_next.vld    = req.valid;
        tok0_next.done   = bad;
        tok0_next.cmd    = req.command;
        tok0_next.key    = req.key[KEY_W-1:0];
        tok0_next.data   = bad ? '0 : req.set_value[CNT_W-1:0];
        tok0_next.status = bad ? ST_BAD : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
        end
        else if (adv)
        begin
            tok0_reg <= tok0_next;
        end
    end

    assign chain[0] = tok0_reg;

    // row of entry cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kct_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    // a word not taken by any cell found the table full; a get then answers a zero count with OK status
    always_comb
    begin
        last = chain[ENTRIES];
        if (last.done)
        begin
            out_cnt_next = last.data;
            out_st_next  = last.status;
        end
        else
        begin
            out_cnt_next = '0;
            out_st_next  = (last.cmd == CMD_GET) ? ST_OK : ST_FULL;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= last.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && last.vld)
        begin
            out_cnt_reg <= out_cnt_next;
            out_st_reg  <= out_st_next;
        end
    end

    assign rsp.valid     = out_vld_reg;
    assign rsp.count_out = out_cnt_reg;
    assign rsp.status    = out_st_reg;

endmodule
`default_nettype wire
